// ----- src/lob_pkg.sv -----
// Shared types and codes for the order book matcher.
`timescale 1ns / 1ps
package lob_pkg;

    // Width of counts and positions, sized for the largest book depth.
    localparam int LOB_CW = 9;

    // Command modes on the input word.
    localparam logic [3:0] MODE_LIM_BUY  = 4'd0;
    localparam logic [3:0] MODE_LIM_SELL = 4'd1;
    localparam logic [3:0] MODE_MKT_BUY  = 4'd2;
    localparam logic [3:0] MODE_MKT_SELL = 4'd3;
    localparam logic [3:0] MODE_PEG_BUY  = 4'd4;
    localparam logic [3:0] MODE_PEG_SELL = 4'd5;
    localparam logic [3:0] MODE_CANCEL   = 4'd6;
    localparam logic [3:0] MODE_CHG_MKT  = 4'd7;
    localparam logic [3:0] MODE_CHG_LIM  = 4'd8;

    // Status codes on the closing word.
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // Table indexes: limit books, market queues, pegged lists.
    localparam logic [2:0] BK_BID   = 3'd0;
    localparam logic [2:0] BK_ASK   = 3'd1;
    localparam logic [2:0] BK_MBUY  = 3'd2;
    localparam logic [2:0] BK_MSELL = 3'd3;
    localparam logic [2:0] BK_PBUY  = 3'd4;
    localparam logic [2:0] BK_PSELL = 3'd5;
    localparam int         NUM_BK   = 6;

    typedef enum logic [2:0] {
        OP_NOP, OP_LIM, OP_MKT, OP_PEG, OP_CAN, OP_CHM, OP_CHL
    } t_op;

    // Decoded command passed from the front end to the execution engine.
    typedef struct packed {
        t_op         op;
        logic        side;
        logic [15:0] id;
        logic [23:0] qty;
        logic [31:0] px;
    } t_cmd;

    typedef enum logic [2:0] {BK_NOP, BK_INS, BK_DEL, BK_SETQ, BK_SCAN} t_bk_op;

    // Scan kinds: insert position in a descending or ascending book,
    // insert position by id, or search for an id.
    typedef enum logic [1:0] {SK_DESC, SK_ASC, SK_ID, SK_FIND} t_scan;

    typedef struct packed {
        t_bk_op            op;
        t_scan             kind;
        logic [LOB_CW-1:0] pos;
        logic [31:0]       px;
        logic [15:0]       id;
        logic [23:0]       qty;
    } t_bk_cmd;

    typedef struct packed {
        logic [LOB_CW-1:0] cnt;
        logic              done;
        logic              found;
        logic [LOB_CW-1:0] pos;
        logic [31:0]       px0;
        logic [15:0]       id0;
        logic [23:0]       qty0;
    } t_bk_stat;

endpackage

// ----- src/lob_if.sv -----
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
interface lob_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mode;
    logic [15:0] order_id;
    logic [23:0] quantity;
    logic [31:0] price;
    modport source(output valid, mode, order_id, quantity, price, input ready);
    modport sink(input valid, mode, order_id, quantity, price, output ready);
endinterface

interface lob_out_if;
    logic        valid;
    logic        ready;
    logic        is_trade;
    logic [31:0] trade_price;
    logic [23:0] trade_quantity;
    logic [1:0]  status;
    logic        last;
    modport source(output valid, is_trade, trade_price, trade_quantity, status, last,
                   input ready);
    modport sink(input valid, is_trade, trade_price, trade_quantity, status, last,
                 output ready);
endinterface

// ----- src/limit_order_book_matcher_top.sv -----
// Top level of the price-time priority order book matcher.
// A command holds the engine through its table scans (insert position or id search),
// which step one entry per cycle, and through each trade that it makes.
// Throughput: one command at a time in the engine; a two-word queue takes the next ones.
// Result words leave through one output register; a stalled output holds the engine.
// Reset (synchronous, active low) empties all tables and queues; entries are not cleared.
`timescale 1ns / 1ps
module limit_order_book_matcher_top #(
    parameter int BOOK_DEPTH   = 16,
    parameter int PEG_DEPTH    = 8,
    parameter int MARKET_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lob_in_if.sink    i_in,
    lob_out_if.source o_out
);
    import lob_pkg::*;

    logic     w_cmd_valid, w_cmd_ready;
    t_cmd     w_cmd;
    t_bk_cmd  w_bk_cmd  [NUM_BK];
    t_bk_stat w_bk_stat [NUM_BK];

    lob_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    lob_engine #(
        .BOOK_DEPTH   (BOOK_DEPTH),
        .PEG_DEPTH    (PEG_DEPTH),
        .MARKET_DEPTH (MARKET_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_bk        (w_bk_cmd),
        .i_bk        (w_bk_stat),
        .o_out       (o_out)
    );

    lob_book #(.DEPTH(BOOK_DEPTH)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_bk_cmd[0]), .o_stat(w_bk_stat[0]));
    lob_book #(.DEPTH(BOOK_DEPTH)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_bk_cmd[1]), .o_stat(w_bk_stat[1]));
    lob_book #(.DEPTH(MARKET_DEPTH)) u_mbuy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_bk_cmd[2]), .o_stat(w_bk_stat[2]));
    lob_book #(.DEPTH(MARKET_DEPTH)) u_msell (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_bk_cmd[3]), .o_stat(w_bk_stat[3]));
    lob_book #(.DEPTH(PEG_DEPTH)) u_pbuy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_bk_cmd[4]), .o_stat(w_bk_stat[4]));
    lob_book #(.DEPTH(PEG_DEPTH)) u_psell (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_bk_cmd[5]), .o_stat(w_bk_stat[5]));

endmodule

// ----- src/lob_front.sv -----
// Front end: accepts command words, decodes them and queues them for the engine.
`timescale 1ns / 1ps
module lob_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lob_in_if.sink        i_in,
    output logic          o_cmd_valid,
    output lob_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);
    import lob_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_cmd       dec;

    // Classify the mode into an operation and a side.
    always_comb begin
        dec.id   = i_in.order_id;
        dec.qty  = i_in.quantity;
        dec.px   = i_in.price;
        dec.side = 1'b0;
        unique case (i_in.mode)
            MODE_LIM_BUY:  dec.op = OP_LIM;
            MODE_LIM_SELL: begin dec.op = OP_LIM; dec.side = 1'b1; end
            MODE_MKT_BUY:  dec.op = OP_MKT;
            MODE_MKT_SELL: begin dec.op = OP_MKT; dec.side = 1'b1; end
            MODE_PEG_BUY:  dec.op = OP_PEG;
            MODE_PEG_SELL: begin dec.op = OP_PEG; dec.side = 1'b1; end
            MODE_CANCEL:   dec.op = OP_CAN;
            MODE_CHG_MKT:  dec.op = OP_CHM;
            MODE_CHG_LIM:  dec.op = OP_CHL;
            default:       dec.op = OP_NOP;
        endcase
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign pop         = o_cmd_valid && i_cmd_ready;

    // Two-entry queue between the front end and the engine.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/lob_book.sv -----
// One sorted table of orders held as a row of cells with shift insert and remove.
`timescale 1ns / 1ps
module lob_book #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lob_pkg::t_bk_cmd  i_cmd,
    output lob_pkg::t_bk_stat o_stat
);
    import lob_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]   r_px  [DEPTH];
    logic [15:0]   r_id  [DEPTH];
    logic [23:0]   r_qty [DEPTH];
    logic [CW-1:0] r_cnt, r_idx, r_pos;
    logic          r_busy, r_done, r_found;
    t_scan         r_kind;
    logic [31:0]   r_kpx;
    logic [15:0]   r_kid;

    logic [CW-1:0] pos;
    logic [31:0]   e_px;
    logic [15:0]   e_id;
    logic          hit;

    assign pos  = i_cmd.pos[CW-1:0];
    assign e_px = r_px[r_idx[IW-1:0]];
    assign e_id = r_id[r_idx[IW-1:0]];

    // Does the scanned entry stop the scan?
    always_comb begin
        unique case (r_kind)
            SK_DESC: hit = (r_kpx > e_px) || (r_kpx == e_px && r_kid < e_id);
            SK_ASC:  hit = (r_kpx < e_px) || (r_kpx == e_px && r_kid < e_id);
            SK_ID:   hit = (r_kid < e_id);
            default: hit = (r_kid == e_id);
        endcase
    end

    // Each cell keeps, takes a neighbor, takes the new entry, or takes a new quantity.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_cmd.op == BK_INS) begin
                if (CW'(g) == pos) begin
                    r_px[g]  <= i_cmd.px;
                    r_id[g]  <= i_cmd.id;
                    r_qty[g] <= i_cmd.qty;
                end else if (CW'(g) > pos) begin
                    if (g > 0) begin
                        r_px[g]  <= r_px[(g > 0) ? g - 1 : 0];
                        r_id[g]  <= r_id[(g > 0) ? g - 1 : 0];
                        r_qty[g] <= r_qty[(g > 0) ? g - 1 : 0];
                    end
                end
            end else if (i_cmd.op == BK_DEL) begin
                if (CW'(g) >= pos && g < DEPTH - 1) begin
                    r_px[g]  <= r_px[(g < DEPTH - 1) ? g + 1 : g];
                    r_id[g]  <= r_id[(g < DEPTH - 1) ? g + 1 : g];
                    r_qty[g] <= r_qty[(g < DEPTH - 1) ? g + 1 : g];
                end
            end else if (i_cmd.op == BK_SETQ) begin
                if (CW'(g) == pos) r_qty[g] <= i_cmd.qty;
            end
        end
    end

    // Count and the sequential scan, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == BK_SCAN) begin
            r_kind <= i_cmd.kind;
            r_kpx  <= i_cmd.px;
            r_kid  <= i_cmd.id;
        end
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_idx   <= '0;
            r_pos   <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.op == BK_INS) r_cnt <= r_cnt + CW'(1);
            else if (i_cmd.op == BK_DEL) r_cnt <= r_cnt - CW'(1);
            if (i_cmd.op == BK_SCAN) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (r_idx >= r_cnt) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b0;
                    r_pos   <= r_cnt;
                end else if (hit) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b1;
                    r_pos   <= r_idx;
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
        end
    end

    assign o_stat.cnt   = LOB_CW'(r_cnt);
    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;
    assign o_stat.pos   = LOB_CW'(r_pos);
    assign o_stat.px0   = r_px[0];
    assign o_stat.id0   = r_id[0];
    assign o_stat.qty0  = r_qty[0];

endmodule

// ----- src/lob_engine.sv -----
// Back end: carries out commands on the tables, matches, and emits result words.
`timescale 1ns / 1ps
module lob_engine #(
    parameter int BOOK_DEPTH   = 16,
    parameter int PEG_DEPTH    = 8,
    parameter int MARKET_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  lob_pkg::t_cmd     i_cmd,
    output logic              o_cmd_ready,
    output lob_pkg::t_bk_cmd  o_bk [lob_pkg::NUM_BK],
    input  lob_pkg::t_bk_stat i_bk [lob_pkg::NUM_BK],
    lob_out_if.source         o_out
);
    import lob_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POS   = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_CHL   = 3'd3;
    localparam logic [2:0] S_SWEEP = 3'd4;
    localparam logic [2:0] S_CROSS = 3'd5;
    localparam logic [2:0] S_STAT  = 3'd6;

    logic [2:0]  r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    logic [2:0]  r_tb, n_tb;
    logic        r_sw, n_sw;
    logic        r_after, n_after;
    logic [1:0]  r_st, n_st;
    logic        r_ov;
    logic        r_out_trade, r_out_last;
    logic [31:0] r_out_px;
    logic [23:0] r_out_qty;
    logic [1:0]  r_out_st;

    logic        out_free, emit, e_trade, e_last;
    logic [31:0] e_px;
    logic [23:0] e_qty;
    logic [1:0]  e_st;
    logic        add_go;
    logic [2:0]  a_tb, sel, mb, lb, pb;
    t_cmd        a_c;
    logic [LOB_CW-1:0] cap [NUM_BK];
    logic [NUM_BK-1:0] dones, founds;
    logic        use_peg, use_pb, use_pa;
    logic [23:0] top_q, mkt_q, bq, aq, tq;

    assign cap[0] = LOB_CW'(BOOK_DEPTH);
    assign cap[1] = LOB_CW'(BOOK_DEPTH);
    assign cap[2] = LOB_CW'(MARKET_DEPTH);
    assign cap[3] = LOB_CW'(MARKET_DEPTH);
    assign cap[4] = LOB_CW'(PEG_DEPTH);
    assign cap[5] = LOB_CW'(PEG_DEPTH);

    assign out_free = !r_ov || o_out.ready;

    // Reduce the head entry: remove it when emptied, else rewrite its quantity.
    function automatic t_bk_cmd take_cmd(logic [23:0] left);
        t_bk_cmd c;
        c     = '0;
        c.op  = (left == 24'd0) ? BK_DEL : BK_SETQ;
        c.qty = left;
        return c;
    endfunction

    always_comb begin
        for (int k = 0; k < NUM_BK; k++) begin
            dones[k]  = i_bk[k].done;
            founds[k] = i_bk[k].found;
        end
    end

    // Heads of the matching tables for the sweep side and for the book cross.
    always_comb begin
        mb      = {2'b01, r_sw};
        lb      = {2'b00, ~r_sw};
        pb      = {2'b10, ~r_sw};
        use_peg = (i_bk[pb].cnt != '0) && (i_bk[pb].id0 < i_bk[lb].id0);
        top_q   = use_peg ? i_bk[pb].qty0 : i_bk[lb].qty0;
        mkt_q   = i_bk[mb].qty0;
        use_pb  = (i_bk[BK_PBUY].cnt != '0) && (i_bk[BK_PBUY].id0 < i_bk[BK_BID].id0);
        use_pa  = (i_bk[BK_PSELL].cnt != '0) && (i_bk[BK_PSELL].id0 < i_bk[BK_ASK].id0);
        bq      = use_pb ? i_bk[BK_PBUY].qty0 : i_bk[BK_BID].qty0;
        aq      = use_pa ? i_bk[BK_PSELL].qty0 : i_bk[BK_ASK].qty0;
        if (r_state == S_CROSS) tq = (bq < aq) ? bq : aq;
        else tq = (mkt_q < top_q) ? mkt_q : top_q;
    end

    // Command sequencer.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_tb        = r_tb;
        n_sw        = r_sw;
        n_after     = r_after;
        n_st        = r_st;
        o_cmd_ready = 1'b0;
        emit        = 1'b0;
        e_trade     = 1'b0;
        e_px        = '0;
        e_qty       = '0;
        e_st        = ST_DONE;
        e_last      = 1'b0;
        add_go      = 1'b0;
        a_tb        = BK_BID;
        a_c         = r_cmd;
        sel         = BK_BID;
        for (int k = 0; k < NUM_BK; k++) o_bk[k] = '0;

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.op)
                        OP_LIM: begin
                            add_go = 1'b1;
                            a_tb   = {2'b00, i_cmd.side};
                            a_c    = i_cmd;
                        end
                        OP_PEG: begin
                            add_go = 1'b1;
                            a_tb   = {2'b10, i_cmd.side};
                            a_c    = i_cmd;
                        end
                        OP_MKT: begin
                            a_tb = {2'b01, i_cmd.side};
                            if (i_cmd.qty == 24'd0) begin
                                n_st    = ST_DONE;
                                n_state = S_STAT;
                            end else if (i_bk[a_tb].cnt >= cap[a_tb]) begin
                                n_st    = ST_FULL;
                                n_state = S_STAT;
                            end else begin
                                o_bk[a_tb].op  = BK_INS;
                                o_bk[a_tb].pos = i_bk[a_tb].cnt;
                                o_bk[a_tb].id  = i_cmd.id;
                                o_bk[a_tb].qty = i_cmd.qty;
                                n_sw    = i_cmd.side;
                                n_after = 1'b0;
                                n_state = S_SWEEP;
                            end
                        end
                        OP_CAN, OP_CHM, OP_CHL: begin
                            for (int k = 0; k < NUM_BK; k++) begin
                                o_bk[k].op   = BK_SCAN;
                                o_bk[k].kind = SK_FIND;
                                o_bk[k].id   = i_cmd.id;
                            end
                            n_state = S_FIND;
                        end
                        default: begin
                            n_st    = ST_DONE;
                            n_state = S_STAT;
                        end
                    endcase
                end
            end
            S_POS: begin
                if (i_bk[r_tb].done) begin
                    o_bk[r_tb].op  = BK_INS;
                    o_bk[r_tb].pos = i_bk[r_tb].pos;
                    o_bk[r_tb].px  = r_cmd.px;
                    o_bk[r_tb].id  = r_cmd.id;
                    o_bk[r_tb].qty = r_cmd.qty;
                    n_sw    = ~r_tb[0];
                    n_after = 1'b1;
                    n_state = S_SWEEP;
                end
            end
            S_FIND: begin
                if (&dones) begin
                    n_st    = ST_NOTFOUND;
                    n_state = S_STAT;
                    if (r_cmd.op == OP_CAN) begin
                        for (int k = NUM_BK - 1; k >= 0; k--) begin
                            if (founds[k]) sel = 3'(k);
                        end
                        if (founds != '0) begin
                            o_bk[sel].op  = BK_DEL;
                            o_bk[sel].pos = i_bk[sel].pos;
                            n_st = ST_DONE;
                        end
                    end else if (r_cmd.op == OP_CHM) begin
                        sel = founds[BK_MBUY] ? BK_MBUY : BK_MSELL;
                        if (founds[BK_MBUY] || founds[BK_MSELL]) begin
                            o_bk[sel].op  = (r_cmd.qty == 24'd0) ? BK_DEL : BK_SETQ;
                            o_bk[sel].pos = i_bk[sel].pos;
                            o_bk[sel].qty = r_cmd.qty;
                            n_st = ST_DONE;
                        end
                    end else begin
                        sel = founds[BK_BID] ? BK_BID : BK_ASK;
                        if (founds[BK_BID] || founds[BK_ASK]) begin
                            o_bk[sel].op  = BK_DEL;
                            o_bk[sel].pos = i_bk[sel].pos;
                            n_tb    = sel;
                            n_state = S_CHL;
                        end
                    end
                end
            end
            S_CHL: begin
                add_go = 1'b1;
                a_tb   = r_tb;
                a_c    = r_cmd;
            end
            S_SWEEP: begin
                if (i_bk[mb].cnt != '0 && i_bk[lb].cnt != '0) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_trade = 1'b1;
                        e_px    = i_bk[lb].px0;
                        e_qty   = tq;
                        o_bk[use_peg ? pb : lb] = take_cmd(top_q - tq);
                        o_bk[mb]                = take_cmd(mkt_q - tq);
                    end
                end else if (r_after) begin
                    n_state = S_CROSS;
                end else begin
                    n_st    = ST_DONE;
                    n_state = S_STAT;
                end
            end
            S_CROSS: begin
                if (i_bk[BK_BID].cnt != '0 && i_bk[BK_ASK].cnt != '0
                        && i_bk[BK_BID].px0 >= i_bk[BK_ASK].px0) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_trade = 1'b1;
                        e_px    = i_bk[BK_BID].px0;
                        e_qty   = tq;
                        o_bk[use_pb ? BK_PBUY : BK_BID]  = take_cmd(bq - tq);
                        o_bk[use_pa ? BK_PSELL : BK_ASK] = take_cmd(aq - tq);
                    end
                end else begin
                    n_st    = ST_DONE;
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_st    = r_st;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Start of a limit or pegged add: drop checks, then the position scan.
        if (add_go) begin
            if (a_c.qty == 24'd0) begin
                n_st    = ST_DONE;
                n_state = S_STAT;
            end else if (i_bk[a_tb].cnt >= cap[a_tb]) begin
                n_st    = ST_FULL;
                n_state = S_STAT;
            end else begin
                o_bk[a_tb].op   = BK_SCAN;
                o_bk[a_tb].kind = a_tb[2] ? SK_ID : (a_tb[0] ? SK_ASC : SK_DESC);
                o_bk[a_tb].px   = a_c.px;
                o_bk[a_tb].id   = a_c.id;
                n_tb    = a_tb;
                n_state = S_POS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_tb    <= n_tb;
        r_sw    <= n_sw;
        r_after <= n_after;
        r_st    <= n_st;
        if (emit) begin
            r_out_trade <= e_trade;
            r_out_px    <= e_px;
            r_out_qty   <= e_qty;
            r_out_st    <= e_st;
            r_out_last  <= e_last;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.is_trade       = r_out_trade;
    assign o_out.trade_price    = r_out_px;
    assign o_out.trade_quantity = r_out_qty;
    assign o_out.status         = r_out_st;
    assign o_out.last           = r_out_last;

    // Trades only come out of the sweep and cross loops.
    a_trade_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && e_trade) |-> (r_state == S_SWEEP || r_state == S_CROSS))
        else $error("trade emitted outside matching");

    // The bid book never holds more than its depth.
    a_bid_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bk[BK_BID].cnt <= LOB_CW'(BOOK_DEPTH))
        else $error("bid book over depth");

    // The closing word ends the command.
    a_stat_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT && out_free) |=> (r_state == S_IDLE))
        else $error("status word did not end command");

endmodule

// ----- test/limit_order_book_matcher_top_test.sv -----
// Self-checking testbench for the order book matcher: directed and random commands.
`timescale 1ns / 1ps
module limit_order_book_matcher_top_test;
    import lob_pkg::*;

    localparam int BOOK_N   = 16;
    localparam int PEG_N    = 8;
    localparam int MKT_N    = 4;
    localparam int MAX_RES  = 2 * (BOOK_N + PEG_N + MKT_N) + 1;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        is_trade;
        logic [31:0] px;
        logic [23:0] qty;
        logic [1:0]  status;
        logic        last;
    } t_fill;

    logic i_clk;
    logic i_rst_n;
    lob_in_if  cmd_ch ();
    lob_out_if fill_ch ();

    limit_order_book_matcher_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch.sink),
        .o_out  (fill_ch.source)
    );

    // Shadow book state.
    logic [31:0] bid_px [BOOK_N];
    logic [15:0] bid_id [BOOK_N];
    logic [23:0] bid_q  [BOOK_N];
    int          bid_n;
    logic [31:0] ask_px [BOOK_N];
    logic [15:0] ask_id [BOOK_N];
    logic [23:0] ask_q  [BOOK_N];
    int          ask_n;
    // Lists: index 0 peg buy, 1 peg sell, 2 market buy, 3 market sell.
    logic [15:0] lst_id [4][PEG_N];
    logic [23:0] lst_q  [4][PEG_N];
    int          lst_n  [4];

    t_fill expected_fills[$];
    int    fill_cnt;
    int    errors;
    int    idle_cycles;
    bit    drain_ready;
    int    stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int lst_cap(int l);
        return (l < 2) ? PEG_N : MKT_N;
    endfunction

    function automatic void push_fill(logic tr, logic [31:0] p, logic [23:0] q,
                                      logic [1:0] st, logic lst);
        t_fill f;
        if (fill_cnt >= MAX_RES) return;
        f = '{tr, p, q, st, lst};
        expected_fills.push_back(f);
        fill_cnt++;
    endfunction

    function automatic int book_insert(int s, logic [15:0] id, logic [23:0] q,
                                       logic [31:0] p);
        int pos;
        int n;
        bit ahead;
        n = (s == 0) ? bid_n : ask_n;
        if (n >= BOOK_N) return 1;
        pos = 0;
        while (pos < n) begin
            if (s == 0) ahead = (p > bid_px[pos]) || (p == bid_px[pos] && id < bid_id[pos]);
            else ahead = (p < ask_px[pos]) || (p == ask_px[pos] && id < ask_id[pos]);
            if (ahead) break;
            pos++;
        end
        for (int i = n; i > pos; i--) begin
            if (s == 0) begin
                bid_px[i] = bid_px[i-1]; bid_id[i] = bid_id[i-1]; bid_q[i] = bid_q[i-1];
            end else begin
                ask_px[i] = ask_px[i-1]; ask_id[i] = ask_id[i-1]; ask_q[i] = ask_q[i-1];
            end
        end
        if (s == 0) begin
            bid_px[pos] = p; bid_id[pos] = id; bid_q[pos] = q; bid_n++;
        end else begin
            ask_px[pos] = p; ask_id[pos] = id; ask_q[pos] = q; ask_n++;
        end
        return 0;
    endfunction

    function automatic void book_remove(int s, int idx);
        int n;
        n = (s == 0) ? bid_n : ask_n;
        for (int i = idx; i + 1 < n; i++) begin
            if (s == 0) begin
                bid_px[i] = bid_px[i+1]; bid_id[i] = bid_id[i+1]; bid_q[i] = bid_q[i+1];
            end else begin
                ask_px[i] = ask_px[i+1]; ask_id[i] = ask_id[i+1]; ask_q[i] = ask_q[i+1];
            end
        end
        if (s == 0) bid_n--;
        else ask_n--;
    endfunction

    function automatic int book_find(int s, logic [15:0] id);
        int n;
        n = (s == 0) ? bid_n : ask_n;
        for (int i = 0; i < n; i++)
            if (((s == 0) ? bid_id[i] : ask_id[i]) == id) return i;
        return -1;
    endfunction

    function automatic int list_insert(int l, logic [15:0] id, logic [23:0] q, bit sorted);
        int pos;
        int n;
        n = lst_n[l];
        if (n >= lst_cap(l)) return 1;
        pos = n;
        if (sorted) begin
            pos = 0;
            while (pos < n && !(id < lst_id[l][pos])) pos++;
        end
        for (int i = n; i > pos; i--) begin
            lst_id[l][i] = lst_id[l][i-1]; lst_q[l][i] = lst_q[l][i-1];
        end
        lst_id[l][pos] = id; lst_q[l][pos] = q;
        lst_n[l]++;
        return 0;
    endfunction

    function automatic void list_remove(int l, int idx);
        for (int i = idx; i + 1 < lst_n[l]; i++) begin
            lst_id[l][i] = lst_id[l][i+1]; lst_q[l][i] = lst_q[l][i+1];
        end
        lst_n[l]--;
    endfunction

    function automatic int list_find(int l, logic [15:0] id);
        for (int i = 0; i < lst_n[l]; i++) if (lst_id[l][i] == id) return i;
        return -1;
    endfunction

    // Best quantity on side s; the first peg wins when its id is smaller.
    function automatic logic [23:0] top_qty(int s, output bit use_peg);
        logic [15:0] lim_id;
        lim_id = (s == 0) ? bid_id[0] : ask_id[0];
        use_peg = (lst_n[s] > 0) && (lst_id[s][0] < lim_id);
        if (use_peg) return lst_q[s][0];
        return (s == 0) ? bid_q[0] : ask_q[0];
    endfunction

    function automatic void top_take(int s, bit use_peg, logic [23:0] t);
        if (use_peg) begin
            lst_q[s][0] -= t;
            if (lst_q[s][0] == 0) list_remove(s, 0);
        end else if (s == 0) begin
            bid_q[0] -= t;
            if (bid_q[0] == 0) book_remove(0, 0);
        end else begin
            ask_q[0] -= t;
            if (ask_q[0] == 0) book_remove(1, 0);
        end
    endfunction

    // Market queue of side s trades against the opposite limit book and pegged list.
    function automatic void sweep_market(int s);
        int o;
        bit up;
        logic [23:0] a;
        logic [23:0] q;
        logic [23:0] t;
        o = 1 - s;
        while (lst_n[2+s] > 0 && ((o == 0) ? bid_n : ask_n) > 0) begin
            a = top_qty(o, up);
            q = lst_q[2+s][0];
            t = (q < a) ? q : a;
            push_fill(1'b1, (o == 0) ? bid_px[0] : ask_px[0], t, ST_DONE, 1'b0);
            top_take(o, up, t);
            lst_q[2+s][0] = q - t;
            if (lst_q[2+s][0] == 0) list_remove(2 + s, 0);
        end
    endfunction

    function automatic void cross_books();
        bit ub;
        bit ua;
        logic [23:0] bq;
        logic [23:0] aq;
        logic [23:0] t;
        while (bid_n > 0 && ask_n > 0 && bid_px[0] >= ask_px[0]) begin
            bq = top_qty(0, ub);
            aq = top_qty(1, ua);
            t = (bq < aq) ? bq : aq;
            push_fill(1'b1, bid_px[0], t, ST_DONE, 1'b0);
            top_take(0, ub, t);
            top_take(1, ua, t);
        end
    endfunction

    function automatic logic [1:0] add_limit(int s, logic [15:0] id, logic [23:0] q,
                                             logic [31:0] p);
        if (q == 0) return ST_DONE;
        if (book_insert(s, id, q, p) != 0) return ST_FULL;
        sweep_market(1 - s);
        cross_books();
        return ST_DONE;
    endfunction

    // Works out every result word of one command and updates the shadow book.
    function automatic void predict_fills(logic [3:0] mode, logic [15:0] id,
                                          logic [23:0] q, logic [31:0] p);
        logic [1:0] st;
        int k;
        bit hit;
        fill_cnt = 0;
        st = ST_DONE;
        hit = 0;
        case (mode)
            MODE_LIM_BUY:  st = add_limit(0, id, q, p);
            MODE_LIM_SELL: st = add_limit(1, id, q, p);
            MODE_MKT_BUY, MODE_MKT_SELL: begin
                k = (mode == MODE_MKT_BUY) ? 0 : 1;
                if (q != 0) begin
                    if (list_insert(2 + k, id, q, 1'b0) != 0) st = ST_FULL;
                    else sweep_market(k);
                end
            end
            MODE_PEG_BUY, MODE_PEG_SELL: begin
                k = (mode == MODE_PEG_BUY) ? 0 : 1;
                if (q != 0) begin
                    if (list_insert(k, id, q, 1'b1) != 0) st = ST_FULL;
                    else begin
                        sweep_market(1 - k);
                        cross_books();
                    end
                end
            end
            MODE_CANCEL: begin
                for (int s = 0; s < 2 && !hit; s++) begin
                    k = book_find(s, id);
                    if (k >= 0) begin book_remove(s, k); hit = 1; end
                end
                for (int l = 2; l < 4 && !hit; l++) begin
                    k = list_find(l, id);
                    if (k >= 0) begin list_remove(l, k); hit = 1; end
                end
                for (int l = 0; l < 2 && !hit; l++) begin
                    k = list_find(l, id);
                    if (k >= 0) begin list_remove(l, k); hit = 1; end
                end
                if (!hit) st = ST_NOTFOUND;
            end
            MODE_CHG_MKT: begin
                for (int l = 2; l < 4 && !hit; l++) begin
                    k = list_find(l, id);
                    if (k >= 0) begin
                        if (q == 0) list_remove(l, k);
                        else lst_q[l][k] = q;
                        hit = 1;
                    end
                end
                if (!hit) st = ST_NOTFOUND;
            end
            MODE_CHG_LIM: begin
                for (int s = 0; s < 2 && !hit; s++) begin
                    k = book_find(s, id);
                    if (k >= 0) begin
                        book_remove(s, k);
                        st = add_limit(s, id, q, p);
                        hit = 1;
                    end
                end
                if (!hit) st = ST_NOTFOUND;
            end
            default: st = ST_DONE;
        endcase
        if (fill_cnt >= MAX_RES) begin
            void'(expected_fills.pop_back());
            fill_cnt--;
        end
        push_fill(1'b0, '0, '0, st, 1'b1);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one command word and records its expected results on acceptance.
    // Valid stays high after acceptance until the next falling edge decides.
    task automatic send_cmd(logic [3:0] mode, logic [15:0] id, logic [23:0] q,
                            logic [31:0] p, bit gaps);
        int gap;
        gap = gaps ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= mode;
        cmd_ch.order_id <= id;
        cmd_ch.quantity <= q;
        cmd_ch.price    <= p;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        predict_fills(mode, id, q, p);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (expected_fills.size() != 0) @(negedge i_clk);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_fill got;
        t_fill want;
        if (i_rst_n && fill_ch.valid && fill_ch.ready) begin
            got = '{fill_ch.is_trade, fill_ch.trade_price, fill_ch.trade_quantity,
                    fill_ch.status, fill_ch.last};
            if (expected_fills.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, got);
                errors++;
            end else begin
                want = expected_fills.pop_front();
                if (got.is_trade !== want.is_trade) begin
                    $display("%0t: is_trade expected %0d actual %0d", $realtime,
                             want.is_trade, got.is_trade);
                    errors++;
                end
                if (got.px !== want.px) begin
                    $display("%0t: trade_price expected %0d actual %0d", $realtime,
                             want.px, got.px);
                    errors++;
                end
                if (got.qty !== want.qty) begin
                    $display("%0t: trade_quantity expected %0d actual %0d", $realtime,
                             want.qty, got.qty);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             want.status, got.status);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %0d actual %0d", $realtime,
                             want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls: short mostly, some long, none while draining fast or in stall mode 0.
    always @(negedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (drain_ready || stall_mode == 0) fill_ch.ready <= 1'b1;
        else if (r < 8) fill_ch.ready <= 1'b0;
        else if (r < 12 && stall_mode == 2) fill_ch.ready <= 1'b0;
        else fill_ch.ready <= (r < 70) ? 1'b1 : fill_ch.ready;
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (fill_ch.valid && fill_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_extremes();
        send_cmd(MODE_LIM_BUY, 16'd10, 24'hFFFFFF, 32'hFFFFFFFF, 0);
        send_cmd(MODE_LIM_SELL, 16'd11, 24'd1, 32'd0, 0);
        send_cmd(MODE_LIM_BUY, 16'hFFFF, 24'd0, 32'd5, 0);
        send_cmd(MODE_MKT_SELL, 16'd12, 24'd0, 32'd0, 0);
        send_cmd(MODE_MKT_SELL, 16'd0, 24'hFFFFFF, 32'hFFFFFFFF, 0);
        send_cmd(MODE_CANCEL, 16'hFFFF, 24'd0, 32'd0, 0);
        send_cmd(4'd9, 16'hAAAA, 24'h555555, 32'hAAAA5555, 0);
        send_cmd(4'd15, 16'h5555, 24'hAAAAAA, 32'h5555AAAA, 0);
        wait_drained();
    endtask

    task automatic test_pegs_and_markets();
        send_cmd(MODE_PEG_BUY, 16'd3, 24'd50, 32'd0, 0);
        send_cmd(MODE_LIM_BUY, 16'd20, 24'd40, 32'd1000, 0);
        send_cmd(MODE_PEG_SELL, 16'd30, 24'd70, 32'd0, 0);
        send_cmd(MODE_LIM_SELL, 16'd4, 24'd100, 32'd990, 0);
        send_cmd(MODE_MKT_BUY, 16'd40, 24'd30, 32'd0, 0);
        send_cmd(MODE_CHG_MKT, 16'd40, 24'd5, 32'd0, 0);
        send_cmd(MODE_CHG_MKT, 16'd41, 24'd5, 32'd0, 0);
        send_cmd(MODE_LIM_SELL, 16'd5, 24'd20, 32'd1200, 0);
        send_cmd(MODE_CHG_LIM, 16'd5, 24'd25, 32'd1100, 0);
        send_cmd(MODE_CHG_LIM, 16'd5, 24'd0, 32'd1100, 0);
        send_cmd(MODE_CHG_LIM, 16'd77, 24'd1, 32'd1, 0);
        send_cmd(MODE_CANCEL, 16'd30, 24'd0, 32'd0, 0);
        wait_drained();
    endtask

    task automatic test_full_tables();
        for (int i = 0; i < BOOK_N + 1; i++)
            send_cmd(MODE_LIM_BUY, 16'(100 + i), 24'd1, 32'(10 + i % 3), 1);
        for (int i = 0; i < PEG_N + 1; i++)
            send_cmd(MODE_PEG_SELL, 16'(300 + i), 24'd2, 32'd0, 1);
        for (int i = 0; i < MKT_N + 1; i++)
            send_cmd(MODE_MKT_BUY, 16'(400 + i), 24'd3, 32'd0, 1);
        // A deep ask sweeps the whole bid side at once.
        send_cmd(MODE_LIM_SELL, 16'd500, 24'hFFFFFF, 32'd0, 1);
        wait_drained();
    endtask

    function automatic logic [15:0] live_id();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0 && bid_n > 0) return bid_id[$urandom_range(0, bid_n - 1)];
        if (r == 1 && ask_n > 0) return ask_id[$urandom_range(0, ask_n - 1)];
        if (r == 2 && lst_n[2] > 0) return lst_id[2][$urandom_range(0, lst_n[2] - 1)];
        return 16'($urandom_range(0, 63));
    endfunction

    task automatic test_random(int count);
        logic [3:0]  mode;
        logic [15:0] id;
        logic [23:0] q;
        logic [31:0] p;
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            mode = 4'($urandom_range(0, 8));
            if (r < 3) mode = 4'($urandom_range(9, 15));
            id = (mode >= MODE_CANCEL) ? live_id() : 16'($urandom_range(0, 63));
            q = 24'($urandom_range(1, 200));
            p = 32'($urandom_range(980, 1020));
            if (r >= 90) begin
                // Noise across the full field ranges.
                id = 16'($urandom);
                q  = (r < 93) ? 24'd0 : 24'($urandom);
                p  = $urandom;
            end
            send_cmd(mode, id, q, p, 1);
            if (n == count / 2) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        drain_ready = 1'b0;
        stall_mode = 0;
        bid_n = 0;
        ask_n = 0;
        lst_n = '{0, 0, 0, 0};
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.mode = '0;
        cmd_ch.order_id = '0;
        cmd_ch.quantity = '0;
        cmd_ch.price = '0;
        fill_ch.ready = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        stall_mode = 1;
        test_pegs_and_markets();
        test_full_tables();
        stall_mode = 2;
        test_random(104);
        stall_mode = 0;
        test_random(104);

        drain_ready = 1'b1;
        wait_drained();
        repeat (200) @(negedge i_clk);
        if (errors == 0 && expected_fills.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
